// File: rtl/button_debounce_press_classifier_unit_macros.svh
// Assertion macros shared by the button debounce and press classifier RTL.
// No dependencies; included by the modules that carry concurrent checks.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define BDPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define BDPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDPC_ASSERT(lbl, clk, rst, prop, msg)
`define BDPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/bdpc_pkg.sv
// Shared types, constants and helpers of the button debounce and press classifier.
// No dependencies; used by every module of the block.
package bdpc_pkg;

  localparam int BUTTONS = 8;
  localparam int BTN_AW  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int BTN_W   = 3;
  localparam int HIST_W  = 32;
  localparam int CNT_W   = 16;
  localparam int DLEN_W  = 6;
  localparam int EN_W    = 7;
  localparam int EV_W    = 3;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [EV_W-1:0] {
    EV_NONE        = 3'd0,
    EV_SHORT       = 3'd1,
    EV_LONG        = 3'd2,
    EV_VLONG       = 3'd3,
    EV_REPEAT      = 3'd4,
    EV_REL_SHORT   = 3'd5,
    EV_REL_LONG    = 3'd6,
    EV_REL_VLONG   = 3'd7
  } event_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_DEBOUNCE_LEN   = 3'd0,
    CFG_SHORT_COUNT    = 3'd1,
    CFG_LONG_COUNT     = 3'd2,
    CFG_LONGLONG_COUNT = 3'd3,
    CFG_REPEAT_START   = 3'd4,
    CFG_REPEAT_PERIOD  = 3'd5,
    CFG_EVENT_ENABLE   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [DLEN_W-1:0] debounce_len;
    logic [CNT_W-1:0]  short_count;
    logic [CNT_W-1:0]  long_count;
    logic [CNT_W-1:0]  longlong_count;
    logic [CNT_W-1:0]  repeat_start;
    logic [CNT_W-1:0]  repeat_period;
    logic [EN_W-1:0]   event_enable;
  } cfg_t;

  typedef struct packed {
    logic [HIST_W-1:0] history;
    logic [CNT_W-1:0]  hold;
    logic [CNT_W-1:0]  phase;
  } entry_t;

  typedef struct packed {
    event_t           ev;
    logic             pressed;
    logic [CNT_W-1:0] hold;
  } result_t;

  // Debounce window: the newest n samples, n clamped to 1..32.
  function automatic logic [HIST_W-1:0] window_mask(input logic [DLEN_W-1:0] len);
    logic [DLEN_W-1:0] n;
    n = (len == '0) ? DLEN_W'(1) : len;
    return ~({HIST_W{1'b1}} << n);
  endfunction

endpackage

// File: rtl/button_debounce_press_classifier_unit.sv
// Button debounce and press classifier. Each input beat carries one poll
// sample (button index, raw level); each output beat carries the event code,
// the button index, the debounced state and the hold count after that sample.
// The block takes one sample per clock cycle while the output side keeps
// tready high. The button's state entry is first read from a memory with a
// registered read port, then evaluated and written back while the result
// lands in the output register.
// Two samples of the same button in consecutive cycles are handled by
// forwarding the last written entry, so no bubble is needed. The only stall
// comes from the output side holding tready low. All state reads as zero
// after reset; no clearing pass is run. Configuration is written through the
// cfg port (always ready) and must only change while the block is idle.
// Depends on bdpc_pkg, bdpc_cfg_regs, bdpc_state_mem and bdpc_eval.
`include "button_debounce_press_classifier_unit_macros.svh"
module button_debounce_press_classifier_unit (
  input  logic                         clk,
  input  logic                         rst,
  // Input sample stream.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [2:0] button, [3] level, [7:4] zero
  // Result stream.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,   // [2:0] event_res, [5:3] event_button,
                                                  // [6] pressed, [22:7] hold_polls, [23] zero
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bdpc_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [bdpc_pkg::CFG_DW-1:0]  cfg_data
);

  bdpc_pkg::cfg_t                 cfg;
  bdpc_pkg::entry_t               mem_rd;
  bdpc_pkg::entry_t               cur;
  bdpc_pkg::entry_t               nxt;
  bdpc_pkg::result_t              res;

  // Stage 1: sample whose entry is being read back.
  logic                           s1_valid;
  logic [bdpc_pkg::BTN_W-1:0]     s1_button;
  logic                           s1_level;
  logic                           s1_in_range;
  logic                           s1_advance;
  logic                           in_accept;
  logic                           mem_we;

  // Last write, kept for forwarding.
  logic                           wb_valid;
  logic [bdpc_pkg::BTN_AW-1:0]    wb_addr;
  bdpc_pkg::entry_t               wb_data;

  // Output register.
  logic                           out_valid;
  bdpc_pkg::event_t               out_event;
  logic [bdpc_pkg::BTN_W-1:0]     out_button;
  logic                           out_pressed;
  logic [bdpc_pkg::CNT_W-1:0]     out_hold;
  logic                           out_rel_event;

  bdpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage 1 moves on whenever the output register is free or being drained.
  assign s1_advance  = !out_valid || m_tready;
  assign s_tready    = !s1_valid || s1_advance;
  assign in_accept   = s_tvalid && s_tready;
  assign s1_in_range = 32'(s1_button) < bdpc_pkg::BUTTONS;
  assign mem_we      = s1_valid && s1_advance && s1_in_range;

  bdpc_state_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (s_tdata[bdpc_pkg::BTN_AW-1:0]),
    .rd_data (mem_rd),
    .wr_en   (mem_we),
    .wr_addr (s1_button[bdpc_pkg::BTN_AW-1:0]),
    .wr_data (nxt)
  );

  // The last write is always the newest copy of its entry, so a match on its
  // address may take it in place of the memory read.
  assign cur = (wb_valid && wb_addr == s1_button[bdpc_pkg::BTN_AW-1:0]) ? wb_data : mem_rd;

  bdpc_eval u_eval (
    .cfg   (cfg),
    .cur   (cur),
    .level (s1_level),
    .nxt   (nxt),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      wb_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (mem_we) begin
        wb_valid <= 1'b1;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_button <= s_tdata[2:0];
      s1_level  <= s_tdata[3];
    end
    if (mem_we) begin
      wb_addr <= s1_button[bdpc_pkg::BTN_AW-1:0];
      wb_data <= nxt;
    end
    if (s1_valid && s1_advance) begin
      out_button <= s1_button;
      // A button outside the table leaves no trace and reports no event, not pressed, zero hold.
      if (s1_in_range) begin
        out_event   <= res.ev;
        out_pressed <= res.pressed;
        out_hold    <= res.hold;
      end else begin
        out_event   <= bdpc_pkg::EV_NONE;
        out_pressed <= 1'b0;
        out_hold    <= '0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_hold, out_pressed, out_button, bdpc_pkg::EV_W'(out_event)};

  // A released button can only report nothing or one of the release classes.
  assign out_rel_event = out_event == bdpc_pkg::EV_NONE
                      || out_event == bdpc_pkg::EV_REL_SHORT
                      || out_event == bdpc_pkg::EV_REL_LONG
                      || out_event == bdpc_pkg::EV_REL_VLONG;

  `BDPC_ASSERT_ALWAYS(a_rst_out, clk, rst |=> !out_valid, "output valid right after reset")
  `BDPC_ASSERT(a_rel_class, clk, rst, out_valid && !out_pressed |-> out_rel_event, "press event while released")
  `BDPC_ASSERT(a_rel_hold, clk, rst, out_valid && !out_pressed |-> (out_hold == '0), "hold count kept while released")
  `BDPC_ASSERT(a_press_hold, clk, rst, out_valid && out_pressed |-> (out_hold != '0), "pressed with zero hold count")

endmodule

// File: rtl/bdpc_cfg_regs.sv
// Configuration register file of the button debounce and press classifier.
// Depends on bdpc_pkg.
module bdpc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bdpc_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [bdpc_pkg::CFG_DW-1:0]   cfg_data,
  output bdpc_pkg::cfg_t                cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_len   <= bdpc_pkg::DLEN_W'(4);
      cfg.short_count    <= bdpc_pkg::CNT_W'(5);
      cfg.long_count     <= bdpc_pkg::CNT_W'(100);
      cfg.longlong_count <= bdpc_pkg::CNT_W'(300);
      cfg.repeat_start   <= '0;
      cfg.repeat_period  <= bdpc_pkg::CNT_W'(10);
      cfg.event_enable   <= '0;
    end else if (cfg_valid) begin
      unique case (bdpc_pkg::cfg_idx_t'(cfg_index))
        bdpc_pkg::CFG_DEBOUNCE_LEN:   cfg.debounce_len   <= cfg_data[bdpc_pkg::DLEN_W-1:0];
        bdpc_pkg::CFG_SHORT_COUNT:    cfg.short_count    <= cfg_data;
        bdpc_pkg::CFG_LONG_COUNT:     cfg.long_count     <= cfg_data;
        bdpc_pkg::CFG_LONGLONG_COUNT: cfg.longlong_count <= cfg_data;
        bdpc_pkg::CFG_REPEAT_START:   cfg.repeat_start   <= cfg_data;
        bdpc_pkg::CFG_REPEAT_PERIOD:  cfg.repeat_period  <= cfg_data;
        bdpc_pkg::CFG_EVENT_ENABLE:   cfg.event_enable   <= cfg_data[bdpc_pkg::EN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/bdpc_state_mem.sv
// Per-button state memory: one entry of history, hold count and repeat phase.
// Depends on bdpc_pkg; entries read as zero until first written after reset.
`include "button_debounce_press_classifier_unit_macros.svh"
module bdpc_state_mem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [bdpc_pkg::BTN_AW-1:0]  rd_addr,
  output bdpc_pkg::entry_t             rd_data,
  input  logic                         wr_en,
  input  logic [bdpc_pkg::BTN_AW-1:0]  wr_addr,
  input  bdpc_pkg::entry_t             wr_data
);

  bdpc_pkg::entry_t               mem [bdpc_pkg::BUTTONS];
  logic [bdpc_pkg::BUTTONS-1:0]   vld;
  bdpc_pkg::entry_t               rd_raw;
  logic                           rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Valid bits stand in for clearing the array at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

  `BDPC_ASSERT(a_vld_set, clk, rst, wr_en |=> vld[$past(wr_addr)], "written entry not marked valid")
  `BDPC_ASSERT_ALWAYS(a_vld_clr, clk, rst |=> (vld == '0), "valid bits survive reset")
  `BDPC_ASSERT(a_rd_zero, clk, rst, !rd_vld |-> (rd_data == '0), "unwritten entry reads nonzero")

endmodule

// File: rtl/bdpc_eval.sv
// Per-sample evaluation: debounce, hold counting, press, repeat and release events.
// Depends on bdpc_pkg; purely combinational.
module bdpc_eval (
  input  bdpc_pkg::cfg_t     cfg,
  input  bdpc_pkg::entry_t   cur,
  input  logic               level,
  output bdpc_pkg::entry_t   nxt,
  output bdpc_pkg::result_t  res
);

  logic [bdpc_pkg::HIST_W-1:0] hist;
  logic [bdpc_pkg::HIST_W-1:0] mask;
  logic [bdpc_pkg::CNT_W-1:0]  sc;
  logic [bdpc_pkg::CNT_W-1:0]  per;
  logic [bdpc_pkg::CNT_W-1:0]  hold_n;
  logic [bdpc_pkg::CNT_W:0]    ph;
  logic                        pr;
  logic                        stepped;
  logic                        rep;
  bdpc_pkg::event_t            ev;

  always_comb begin
    hist    = {cur.history[bdpc_pkg::HIST_W-2:0], level};
    mask    = bdpc_pkg::window_mask(cfg.debounce_len);
    pr      = (hist & mask) == mask;
    sc      = (cfg.short_count == '0) ? bdpc_pkg::CNT_W'(1) : cfg.short_count;
    per     = (cfg.repeat_period == '0) ? bdpc_pkg::CNT_W'(1) : cfg.repeat_period;
    stepped = 1'b0;
    rep     = 1'b0;
    ph      = '0;
    ev      = bdpc_pkg::EV_NONE;
    hold_n  = '0;
    nxt     = '0;
    nxt.history = hist;

    if (pr) begin
      stepped = cur.hold != bdpc_pkg::CNT_MAX;
      hold_n  = stepped ? cur.hold + bdpc_pkg::CNT_W'(1) : cur.hold;
      // Repeat phase runs once the hold passes the start point.
      if (cfg.repeat_start != '0 && hold_n > cfg.repeat_start) begin
        ph = {1'b0, cur.phase} + (bdpc_pkg::CNT_W+1)'(1);
        if (ph >= {1'b0, per}) begin
          ph  = '0;
          rep = 1'b1;
        end
      end
      priority if (stepped && cfg.longlong_count != '0 && hold_n == cfg.longlong_count) begin
        ev = bdpc_pkg::EV_VLONG;
      end else if (stepped && cfg.long_count != '0 && hold_n == cfg.long_count) begin
        ev = bdpc_pkg::EV_LONG;
      end else if (stepped && hold_n == sc) begin
        ev = bdpc_pkg::EV_SHORT;
      end else if (rep) begin
        ev = bdpc_pkg::EV_REPEAT;
      end else begin
        ev = bdpc_pkg::EV_NONE;
      end
      nxt.hold  = hold_n;
      nxt.phase = ph[bdpc_pkg::CNT_W-1:0];
    end else begin
      priority if (cfg.longlong_count != '0 && cur.hold >= cfg.longlong_count) begin
        ev = bdpc_pkg::EV_REL_VLONG;
      end else if (cfg.long_count != '0 && cur.hold >= cfg.long_count) begin
        ev = bdpc_pkg::EV_REL_LONG;
      end else if (cur.hold >= sc) begin
        ev = bdpc_pkg::EV_REL_SHORT;
      end else begin
        ev = bdpc_pkg::EV_NONE;
      end
    end

    if (ev != bdpc_pkg::EV_NONE
        && !cfg.event_enable[bdpc_pkg::EV_W'(ev) - bdpc_pkg::EV_W'(1)]) begin
      ev = bdpc_pkg::EV_NONE;
    end

    res.ev      = ev;
    res.pressed = pr;
    res.hold    = hold_n;
  end

endmodule

// File: tb/sv/bdpc_checker.sv
// Scoreboard for the button debounce and press classifier: it watches the sample,
// result and register channels, predicts each result and compares it field by field.
// Depends on bdpc_pkg for the event codes, register indexes and field widths.
module bdpc_checker import bdpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,   // [2:0] button, [3] level, [7:4] zero
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [23:0]       m_tdata,   // [2:0] event_res, [5:3] event_button,
                                       // [6] pressed, [22:7] hold_polls, [23] zero
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output int unsigned       fail_count,
  output int unsigned       pending,
  output int unsigned       results_seen,
  output int unsigned       events_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    event_t            ev;
    logic [BTN_W-1:0]  btn;
    logic              pressed;
    logic [CNT_W-1:0]  hold;
  } poll_result_t;

  poll_result_t      expected_results[$];

  // Private copy of the per-button state.
  logic [HIST_W-1:0] history   [BUTTONS];
  logic [CNT_W-1:0]  hold_cnt  [BUTTONS];
  logic [CNT_W-1:0]  rep_phase [BUTTONS];

  // Private copy of the registers.
  logic [DLEN_W-1:0] dlen;
  logic [CNT_W-1:0]  short_cnt, long_cnt, vlong_cnt, rep_start, rep_period;
  logic [EN_W-1:0]   ev_enable;

  // Advances one button's state by one sample and returns the result it gives.
  function automatic poll_result_t classify_poll(input logic [BTN_W-1:0] b,
                                                 input logic lvl);
    poll_result_t      r;
    logic [HIST_W-1:0] win;
    logic [CNT_W-1:0]  sc, per, hold;
    logic [CNT_W:0]    ph;
    int unsigned       n;
    logic              stepped, rep;
    r.ev      = EV_NONE;
    r.btn     = b;
    r.pressed = 1'b0;
    r.hold    = '0;
    if (b < BUTTONS) begin
      n   = (dlen == '0) ? 1 : dlen;
      win = (n >= HIST_W) ? '1 : (HIST_W'(1) << n) - 1'b1;
      sc  = (short_cnt == '0) ? CNT_W'(1) : short_cnt;
      per = (rep_period == '0) ? CNT_W'(1) : rep_period;
      history[b] = {history[b][HIST_W-2:0], lvl};
      r.pressed  = ((history[b] & win) == win);
      hold       = hold_cnt[b];
      if (r.pressed) begin
        stepped = 1'b0;
        rep     = 1'b0;
        if (hold != CNT_MAX) begin
          hold    = hold + 1'b1;
          stepped = 1'b1;
        end
        if (rep_start != '0 && hold > rep_start) begin
          ph = {1'b0, rep_phase[b]} + 1'b1;
          if (ph >= {1'b0, per}) begin
            ph  = '0;
            rep = 1'b1;
          end
          rep_phase[b] = ph[CNT_W-1:0];
        end else begin
          rep_phase[b] = '0;
        end
        // The very long threshold wins over long, long over short, all over repeat.
        if (stepped && vlong_cnt != '0 && hold == vlong_cnt) r.ev = EV_VLONG;
        else if (stepped && long_cnt != '0 && hold == long_cnt) r.ev = EV_LONG;
        else if (stepped && hold == sc) r.ev = EV_SHORT;
        else if (rep) r.ev = EV_REPEAT;
        hold_cnt[b] = hold;
      end else begin
        if (vlong_cnt != '0 && hold >= vlong_cnt) r.ev = EV_REL_VLONG;
        else if (long_cnt != '0 && hold >= long_cnt) r.ev = EV_REL_LONG;
        else if (hold >= sc) r.ev = EV_REL_SHORT;
        hold         = '0;
        hold_cnt[b]  = '0;
        rep_phase[b] = '0;
      end
      if (r.ev != EV_NONE && !ev_enable[r.ev - 1]) r.ev = EV_NONE;
      r.hold = hold;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    poll_result_t got, want;
    if (rst) begin
      for (int i = 0; i < BUTTONS; i++) begin
        history[i]   = '0;
        hold_cnt[i]  = '0;
        rep_phase[i] = '0;
      end
      dlen       = 6'd4;
      short_cnt  = 16'd5;
      long_cnt   = 16'd100;
      vlong_cnt  = 16'd300;
      rep_start  = 16'd0;
      rep_period = 16'd10;
      ev_enable  = '0;
      expected_results.delete();
    end else begin
      // Results are matched before new samples are queued, so a result beat can
      // never be paired with a sample accepted on the same edge.
      if (m_tvalid && m_tready) begin
        got.ev      = event_t'(m_tdata[2:0]);
        got.btn     = m_tdata[5:3];
        got.pressed = m_tdata[6];
        got.hold    = m_tdata[22:7];
        results_seen++;
        if (got.ev != EV_NONE) events_seen++;
        if (expected_results.size() == 0) begin
          $error("result beat for button %0d with no sample outstanding", got.btn);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.ev !== want.ev) begin
            $error("event_res: expected %0d, actual %0d", want.ev, got.ev);
            fail_count++;
          end
          if (got.btn !== want.btn) begin
            $error("event_button: expected %0d, actual %0d", want.btn, got.btn);
            fail_count++;
          end
          if (got.pressed !== want.pressed) begin
            $error("pressed: expected %0d, actual %0d", want.pressed, got.pressed);
            fail_count++;
          end
          if (got.hold !== want.hold) begin
            $error("hold_polls: expected %0d, actual %0d", want.hold, got.hold);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEBOUNCE_LEN:   dlen       = cfg_data[DLEN_W-1:0];
          CFG_SHORT_COUNT:    short_cnt  = cfg_data;
          CFG_LONG_COUNT:     long_cnt   = cfg_data;
          CFG_LONGLONG_COUNT: vlong_cnt  = cfg_data;
          CFG_REPEAT_START:   rep_start  = cfg_data;
          CFG_REPEAT_PERIOD:  rep_period = cfg_data;
          CFG_EVENT_ENABLE:   ev_enable  = cfg_data[EN_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(classify_poll(s_tdata[2:0], s_tdata[3]));
    end
    pending = expected_results.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Top of the testbench for the button debounce and press classifier: clock, reset,
// sample and register stimulus, result back-pressure, watchdog and the final verdict.
// Depends on bdpc_pkg, bdpc_checker and button_debounce_press_classifier_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdpc_pkg::*;

  // Cycles the result side holds tready low once, to back the block up.
  localparam int unsigned HOLD_OFF_CYCLES = 40;
  // Cycles without any beat on any channel before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  // Margin after the last result before the block is taken as idle.
  localparam int unsigned DRAIN_CYCLES    = 6;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [23:0]       m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data  = '0;

  int unsigned fail_count, pending, results_seen, events_seen;

  // Flags shared between the sample process and the result process, and run counters.
  bit          no_idle      = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned polls_sent   = 0;
  int unsigned settings_run = 0;
  int unsigned quiet_cycles = 0;

  button_debounce_press_classifier_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bdpc_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .events_seen  (events_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one sample beat, sometimes after a short gap, and returns on the edge
  // that accepts it. Valid is left high so that back-to-back beats never drop it.
  // Ready is sampled at the falling edge, where every input has long settled.
  task automatic send_poll(input logic [BTN_W-1:0] b, input logic lvl);
    logic rdy;
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, lvl, b};
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    polls_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] val);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // Stops offering samples and waits until every result is back, then for the
  // DRAIN_CYCLES margin so the block is truly idle before registers change.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_cfg(input cfg_t c);
    write_reg(CFG_DEBOUNCE_LEN,   CFG_DW'(c.debounce_len));
    write_reg(CFG_SHORT_COUNT,    c.short_count);
    write_reg(CFG_LONG_COUNT,     c.long_count);
    write_reg(CFG_LONGLONG_COUNT, c.longlong_count);
    write_reg(CFG_REPEAT_START,   c.repeat_start);
    write_reg(CFG_REPEAT_PERIOD,  c.repeat_period);
    write_reg(CFG_EVENT_ENABLE,   CFG_DW'(c.event_enable));
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // One register setting followed by random press episodes. Most episodes are a
  // held button (with rare glitches and stray samples of other buttons mixed in)
  // and a short release; the rest are plain noise samples. Hold lengths reach a
  // little past the highest threshold but at most 48, so its events can show up.
  task automatic run_phase(input cfg_t c, input int unsigned n_polls, input bit squeeze);
    int unsigned span, thr, win, stop_at, len;
    logic [BTN_W-1:0] b;
    wait_idle();
    program_cfg(c);
    if (squeeze) hold_off_req = 1'b1;
    win = (c.debounce_len > 32) ? 32 : c.debounce_len;
    thr = c.short_count;
    if (c.long_count > thr) thr = c.long_count;
    if (c.longlong_count > thr) thr = c.longlong_count;
    if (c.repeat_start + 3 * c.repeat_period > thr) thr = c.repeat_start + 3 * c.repeat_period;
    span = win + thr + 4;
    if (span > 48) span = 48;
    stop_at = polls_sent + n_polls;
    while (polls_sent < stop_at) begin
      b = BTN_W'($urandom_range(0, BUTTONS - 1));
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(0, span);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0)
            send_poll(BTN_W'($urandom_range(0, BUTTONS - 1)), 1'($urandom_range(0, 1)));
          send_poll(b, $urandom_range(0, 29) != 0);
        end
        repeat ($urandom_range(1, 3)) send_poll(b, 1'b0);
      end else begin
        send_poll(b, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Result side: random short stalls, one long hold-off on request, and none at
  // all once the quiet closing phase starts.
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        m_tready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: any beat on any channel resets the count of quiet cycles.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t setting;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: every event is masked, so only pressed and the count show.
    send_poll(3'd0, 1'b1);
    send_poll(3'd7, 1'b1);
    send_poll(3'd7, 1'b0);
    send_poll(3'd0, 1'b0);

    // Tight thresholds with everything enabled: button 7 walks through short,
    // long, a repeat, very long, another repeat and a very long release;
    // button 0 gives a short and a long release.
    // Fields: debounce_len, short, long, longlong, repeat_start, repeat_period, enable.
    wait_idle();
    program_cfg('{6'd1, 16'd2, 16'd4, 16'd6, 16'd3, 16'd2, 7'h7F});
    repeat (7) send_poll(3'd7, 1'b1);
    send_poll(3'd7, 1'b0);
    repeat (3) send_poll(3'd0, 1'b1);
    send_poll(3'd0, 1'b0);
    repeat (4) send_poll(3'd0, 1'b1);
    send_poll(3'd0, 1'b0);

    // Low extremes: one-sample debounce, a repeat on every poll past the start.
    run_phase('{6'd1, 16'd1, 16'd3, 16'd5, 16'd2, 16'd1, 7'h7F}, 200, 1'b0);
    // Zero registers: debounce and short act as 1, repeat period as 1, long,
    // very long and repeat are off.
    run_phase('{6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'h7F}, 200, 1'b0);
    // Random moderate setting, with the long back-pressure hold-off.
    setting.debounce_len   = DLEN_W'($urandom_range(1, 6));
    setting.short_count    = CNT_W'($urandom_range(1, 6));
    setting.long_count     = CNT_W'($urandom_range(0, 20));
    setting.longlong_count = CNT_W'($urandom_range(0, 40));
    setting.repeat_start   = CNT_W'($urandom_range(0, 12));
    setting.repeat_period  = CNT_W'($urandom_range(0, 5));
    setting.event_enable   = EN_W'($urandom_range(0, 127));
    run_phase(setting, 200, 1'b1);
    // Full 32-sample debounce window.
    run_phase('{6'd32, 16'd2, 16'd8, 16'd12, 16'd4, 16'd3, 7'h7F}, 200, 1'b0);
    // High extremes: debounce above 32 acts as 32, thresholds at the top, all masked.
    run_phase('{6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h00}, 200, 1'b0);

    // Closing phase with another random setting and no idling on either side.
    no_idle = 1'b1;
    setting.debounce_len   = DLEN_W'($urandom_range(1, 5));
    setting.short_count    = CNT_W'($urandom_range(1, 5));
    setting.long_count     = CNT_W'($urandom_range(0, 16));
    setting.longlong_count = CNT_W'($urandom_range(0, 30));
    setting.repeat_start   = CNT_W'($urandom_range(0, 10));
    setting.repeat_period  = CNT_W'($urandom_range(0, 4));
    setting.event_enable   = EN_W'($urandom_range(0, 127));
    run_phase(setting, 200, 1'b0);

    wait_idle();
    $display("Run covered %0d sample beats over %0d register settings, including one long",
             polls_sent, settings_run);
    $display("result-side hold-off; %0d result beats checked, %0d carried an event.",
             results_seen, events_seen);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
